@@ rtl/heat_stencil_5pt_stream_macros.svh @@
// ----------------------------------------------------------------------------
// Heat stencil assertion macros
// Shared concurrent assertion shorthands for the stencil checker.
// ----------------------------------------------------------------------------
`ifndef HEAT_STENCIL_5PT_STREAM_MACROS_SVH
`define HEAT_STENCIL_5PT_STREAM_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define HS5_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that stays live through reset.
`define HS5_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/hs5_pkg.sv @@
// ----------------------------------------------------------------------------
// hs5_pkg
// Types and constants shared by the 5-point heat stencil block.
// ----------------------------------------------------------------------------
package hs5_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int TEMP_W        = 9 + FRAC_BITS;
  localparam int COL_W         = 10;
  localparam int ROW_W         = 16;
  localparam int GW_W          = 11;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int MAX_WIDTH_DEF = 1024;

  // sum of five cells needs three extra bits
  localparam int SUM_W = TEMP_W + 3;

  // floor(n/5) = (n * ceil(2^30/5)) >> 30, exact for n < 2^30
  localparam int                  DIV5_MUL_W = 28;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 28'd214748365;
  localparam int                  DIV5_SHIFT = 30;

  localparam int OUTQ_DEPTH = 8;

  localparam logic [GW_W-1:0]  GRID_WIDTH_RST  = 11'd1000;
  localparam logic [ROW_W-1:0] GRID_HEIGHT_RST = 16'd1000;
  localparam logic [COL_W-1:0] HOT_COL_RST     = 10'd250;
  localparam logic [ROW_W-1:0] HOT_ROW_RST     = 16'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_HOT_COL     = 2'd2,
    REG_HOT_ROW     = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ST_RUN  = 1'b0,
    ST_LEFT = 1'b1
  } fsm_t;

  // one line buffer entry: row above and current row
  typedef struct packed {
    logic [TEMP_W-1:0] up;
    logic [TEMP_W-1:0] mid;
  } line_entry_t;

  // operands of one stencil update, right neighbour arrives in the cycle after
  typedef struct packed {
    logic [TEMP_W-1:0] c;
    logic [TEMP_W-1:0] u;
    logic [TEMP_W-1:0] l;
    logic [TEMP_W-1:0] d;
    logic              has_r;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              last;
    logic              is_src;
  } stencil_op_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              last;
  } result_t;

endpackage

@@ rtl/hs5_ram.sv @@
// ----------------------------------------------------------------------------
// hs5_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hs5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/hs5_calc.sv @@
// ----------------------------------------------------------------------------
// hs5_calc
// Stencil arithmetic: five-term sum, divide by five, source override.
// ----------------------------------------------------------------------------
module hs5_calc
  import hs5_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  input  stencil_op_t       op,
  input  logic [TEMP_W-1:0] r_mid,
  output logic              res_valid,
  output result_t           res
);

  localparam int PROD_W = SUM_W + DIV5_MUL_W;

  logic              b_valid;
  stencil_op_t       b_op;
  logic              s_valid;
  stencil_op_t       s_op;
  logic [SUM_W-1:0]  s_sum;
  logic              p_valid;
  stencil_op_t       p_op;
  logic [PROD_W-1:0] p_prod;

  logic [TEMP_W-1:0] r_sel;
  logic [SUM_W-1:0]  sum;
  logic [TEMP_W-1:0] quot;

  // right neighbour is the RAM word read at accept, valid in the cycle after
  assign r_sel = b_op.has_r ? r_mid : b_op.c;
  assign sum   = SUM_W'(b_op.c) + SUM_W'(b_op.l) + SUM_W'(r_sel)
               + SUM_W'(b_op.u) + SUM_W'(b_op.d);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      s_valid <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      b_valid <= op_valid;
      s_valid <= b_valid;
      p_valid <= s_valid;
    end
    b_op   <= op;
    s_op   <= b_op;
    s_sum  <= sum;
    p_op   <= s_op;
    p_prod <= PROD_W'(s_sum) * PROD_W'(DIV5_MUL);
  end

  assign quot      = p_prod[DIV5_SHIFT +: TEMP_W];
  assign res_valid = p_valid;
  assign res.temp  = p_op.is_src ? p_op.c : quot;
  assign res.col   = p_op.col;
  assign res.row   = p_op.row;
  assign res.last  = p_op.last;

endmodule

@@ rtl/hs5_outq.sv @@
// ----------------------------------------------------------------------------
// hs5_outq
// Small result queue between the arithmetic pipe and the output channel.
// ----------------------------------------------------------------------------
module hs5_outq
  import hs5_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    head_valid,
  output result_t head_data
);

  localparam int QW = $clog2(OUTQ_DEPTH);
  localparam int PW = $clog2(OUTQ_DEPTH + 1);

  result_t         slots [OUTQ_DEPTH];
  logic [QW-1:0]   wr_ptr;
  logic [QW-1:0]   rd_ptr;
  logic [PW-1:0]   count;
  logic            do_pop;

  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
    return (p == QW'(OUTQ_DEPTH - 1)) ? '0 : p + QW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !do_pop) begin
        count <= count + PW'(1);
      end else if (!push && do_pop) begin
        count <= count - PW'(1);
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/heat_stencil_5pt_stream.sv @@
// ----------------------------------------------------------------------------
// heat_stencil_5pt_stream
// Path: a result passes the b, s and p registers of hs5_calc, then the output queue.
// Throughput: one beat per cycle via the next-column prefetch; a beat whose column was
// not prefetched (after reset, a geometry change or a cut drain) waits for a refetch,
// left upper value first if column > 0; input also holds while 8 results sit in pipe and queue.
// Reset (sync, active high) clears counters, FSM and queue; RAM is not cleared.
// ----------------------------------------------------------------------------
module heat_stencil_5pt_stream
  import hs5_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  input  logic [TEMP_W-1:0]    temperature,
  // output channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TEMP_W-1:0]    new_temperature,
  output logic [COL_W-1:0]     col,
  output logic [ROW_W-1:0]     row,
  output logic                 frame_last
);

  localparam int AW = $clog2(MAX_WIDTH);              // column index
  localparam int CW = AW + 1;                         // column count
  localparam int WW = (CW > GW_W) ? CW : GW_W;        // width clamp compare
  localparam int XW = (AW > COL_W) ? AW : COL_W;      // source column compare
  localparam int PW = $clog2(OUTQ_DEPTH + 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [GW_W-1:0]  grid_width;
  logic [ROW_W-1:0] grid_height;
  logic [COL_W-1:0] hot_col;
  logic [ROW_W-1:0] hot_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RST;
      grid_height <= GRID_HEIGHT_RST;
      hot_col     <= HOT_COL_RST;
      hot_row     <= HOT_ROW_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width  <= cfg_wdata[GW_W-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_wdata[ROW_W-1:0];
        REG_HOT_COL:     hot_col     <= cfg_wdata[COL_W-1:0];
        REG_HOT_ROW:     hot_row     <= cfg_wdata[ROW_W-1:0];
      endcase
    end
  end

  // Effective geometry: zero acts as one, width saturates at the buffer depth.
  logic [WW-1:0]    gw_ext;
  logic [CW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;

  assign gw_ext = WW'(grid_width);
  always_comb begin
    if (gw_ext == '0) begin
      w_eff = CW'(1);
    end else if (gw_ext > WW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(gw_ext);
    end
  end
  assign h_eff = (grid_height == '0) ? ROW_W'(1) : grid_height;

  // --------------------------------------------------------------------------
  // Stream position
  // --------------------------------------------------------------------------
  logic [AW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic [AW-1:0]    drain_col;
  logic             draining;

  logic [AW-1:0]    col_cl;
  logic [AW-1:0]    drain_cl;
  logic             stray;
  logic [AW-1:0]    x;
  logic [ROW_W-1:0] row_c;
  logic [CW-1:0]    x_inc;
  logic             last_col;
  logic [AW-1:0]    nxt;
  logic [ROW_W:0]   row_inc;
  logic             last_row;
  logic [ROW_W-1:0] y;
  logic             has_res;

  // A shrunk width pulls a stale column back onto the last column.
  assign col_cl   = (CW'(col_count) >= w_eff) ? AW'(w_eff - CW'(1)) : col_count;
  assign drain_cl = (CW'(drain_col) >= w_eff) ? AW'(w_eff - CW'(1)) : drain_col;

  // Drain outside a drain phase: accepted and dropped, nothing changes.
  assign stray = cmd && !draining;

  // A cell beat during a drain abandons it and restarts the frame at row 0.
  assign row_c    = draining ? '0 : row_count;
  assign x        = cmd ? drain_cl : (draining ? '0 : col_cl);
  assign x_inc    = CW'(x) + CW'(1);
  assign last_col = (x_inc >= w_eff);
  assign nxt      = last_col ? '0 : AW'(x_inc);
  assign row_inc  = {1'b0, row_c} + (ROW_W + 1)'(1);
  assign last_row = (row_inc >= {1'b0, h_eff});

  // Drain beats emit the held last row; cell beats emit the row above them.
  assign y       = cmd ? row_count : row_c - ROW_W'(1);
  assign has_res = cmd || (row_c != '0);

  // --------------------------------------------------------------------------
  // Line buffer: entry x holds {row above, current row} at column x.
  // Each take prefetches the column the next beat will use; the FSM refetches otherwise.
  // --------------------------------------------------------------------------
  line_entry_t   rd_data;
  logic [2*TEMP_W-1:0] rd_raw;
  line_entry_t   cur;
  line_entry_t   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          take;

  logic          fwd;        // last read collided with the write, use fwd_data
  line_entry_t   fwd_data;
  logic          win_valid;  // cur holds entry win_x and l_reg its left upper
  logic [AW-1:0] win_x;
  logic [TEMP_W-1:0] l_reg;
  logic [AW-1:0] fetch_x;

  assign rd_data = line_entry_t'(rd_raw);
  assign cur     = fwd ? fwd_data : rd_data;

  // cell: shift row down, store new cell; drain: shift row down only
  assign wr_data.up  = cur.mid;
  assign wr_data.mid = cmd ? cur.mid : temperature;

  hs5_ram #(
    .WIDTH ($bits(line_entry_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (take),
    .waddr (x),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_raw)
  );

  // --------------------------------------------------------------------------
  // Window refetch FSM. When the beat's column differs from the prefetched
  // one, fetch the left neighbour's upper value (if any), then the column.
  // --------------------------------------------------------------------------
  fsm_t          state;
  fsm_t          state_next;
  logic          fetch;
  logic [AW-1:0] fetch_addr;
  logic          win_ok;
  logic          room;
  logic [PW-1:0] pending;
  logic          out_pop;

  assign win_ok = win_valid && (win_x == x);
  assign room   = (pending < PW'(OUTQ_DEPTH));

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    fetch      = 1'b0;
    fetch_addr = x;
    unique case (state)
      ST_RUN: begin
        if (stray) begin
          in_ready = 1'b1;
        end else begin
          in_ready = win_ok && room;
          if (in_valid && !win_ok) begin
            fetch = 1'b1;
            if (x != '0) begin
              fetch_addr = x - AW'(1);
              state_next = ST_LEFT;
            end
          end
        end
      end
      ST_LEFT: begin
        fetch      = 1'b1;
        fetch_addr = fetch_x;
        state_next = ST_RUN;
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  assign take    = in_valid && in_ready && !stray;
  assign rd_en   = take || fetch;
  assign rd_addr = take ? nxt : fetch_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
      fwd       <= 1'b0;
    end else if (take) begin
      // next column's left upper value is this column's old middle
      win_valid <= 1'b1;
      fwd       <= (x == nxt);
    end else if (fetch) begin
      fwd <= 1'b0;
      if (state == ST_LEFT || x == '0) begin
        win_valid <= 1'b1;
      end else begin
        win_valid <= 1'b0;
      end
    end
    if (take) begin
      win_x    <= nxt;
      l_reg    <= cur.mid;
      fwd_data <= wr_data;
    end else if (fetch) begin
      if (state == ST_LEFT) begin
        l_reg <= cur.up;
        win_x <= fetch_x;
      end else if (x != '0) begin
        fetch_x <= x;
      end else begin
        win_x <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Position counters
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      drain_col <= '0;
      draining  <= 1'b0;
    end else if (take) begin
      if (cmd) begin
        if (last_col) begin
          draining  <= 1'b0;
          drain_col <= '0;
          row_count <= '0;
        end else begin
          drain_col <= AW'(x_inc);
        end
      end else begin
        col_count <= last_col ? '0 : AW'(x_inc);
        drain_col <= '0;
        if (last_col && last_row) begin
          draining  <= 1'b1;
          row_count <= row_c;
        end else begin
          draining  <= 1'b0;
          row_count <= last_col ? ROW_W'(row_inc) : row_c;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Operand selection; missing neighbours fall back to the cell itself.
  // --------------------------------------------------------------------------
  stencil_op_t op;
  logic        has_up;

  assign has_up    = (y != '0);
  assign op.c      = cur.mid;
  assign op.u      = has_up ? cur.up : cur.mid;
  assign op.l      = (x != '0) ? l_reg : cur.mid;
  assign op.d      = cmd ? cur.mid : temperature;
  assign op.has_r  = !last_col;
  assign op.col    = COL_W'(x);
  assign op.row    = y;
  assign op.last   = cmd && last_col;
  assign op.is_src = (XW'(x) == XW'(hot_col)) && (y == hot_row);

  logic    res_valid;
  result_t res;
  result_t head;

  hs5_calc u_calc (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (take && has_res),
    .op        (op),
    .r_mid     (cur.mid),
    .res_valid (res_valid),
    .res       (res)
  );

  // --------------------------------------------------------------------------
  // Output queue; pending counts results in the pipe and in the queue so a
  // beat is only taken when its result has a slot.
  // --------------------------------------------------------------------------
  hs5_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .pop        (out_ready),
    .head_valid (out_valid),
    .head_data  (head)
  );

  assign out_pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if ((take && has_res) && !out_pop) begin
      pending <= pending + PW'(1);
    end else if (!(take && has_res) && out_pop) begin
      pending <= pending - PW'(1);
    end
  end

  assign new_temperature = head.temp;
  assign col             = head.col;
  assign row             = head.row;
  assign frame_last      = head.last;

endmodule

@@ rtl/hs5_checker.sv @@
// ----------------------------------------------------------------------------
// hs5_checker
// Port-level assertions for the heat stencil block, bound to the top level.
// ----------------------------------------------------------------------------
`include "heat_stencil_5pt_stream_macros.svh"

module hs5_checker
  import hs5_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [TEMP_W-1:0] new_temperature,
  input logic [COL_W-1:0]  col,
  input logic [ROW_W-1:0]  row,
  input logic              frame_last
);

  // stalled result beat holds
  `HS5_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(new_temperature) && $stable(col) && $stable(row) && $stable(frame_last), "output beat changed while stalled")

  // reset empties the result path
  `HS5_ASSERT_RST(a_rst_empty, clk, rst |=> !out_valid, "result visible after reset")

  // a fresh result traces back to an accepted input beat through the calc pipe and queue
  `HS5_ASSERT(a_latency, clk, rst, $rose(out_valid) |-> $past(in_valid && in_ready, 4), "result without input beat four cycles earlier")

endmodule

bind heat_stencil_5pt_stream hs5_checker u_hs5_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .new_temperature (new_temperature),
  .col             (col),
  .row             (row),
  .frame_last      (frame_last)
);

@@ tb/heat_stencil_5pt_stream_tb.sv @@
// ----------------------------------------------------------------------------
// heat_stencil_5pt_stream_tb
// Self-checking bench for the 5-point heat stencil stream. A scoreboard class
// keeps its own line buffers, counters and copy of the geometry registers,
// works out each updated cell from every accepted beat, and compares the
// block's results in order. Directed frames come first, then random frames
// over many geometries, then the size extremes, under random input gaps,
// random output stalls and long output hold-offs.
// ----------------------------------------------------------------------------
module heat_stencil_5pt_stream_tb
  import hs5_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // beat commands
  localparam bit CMD_CELL  = 1'b0;
  localparam bit CMD_DRAIN = 1'b1;

  localparam logic [TEMP_W-1:0] T_HOT  = '1;
  localparam logic [TEMP_W-1:0] T_COLD = '0;

  // receiver stall patterns
  localparam int unsigned RX_OPEN   = 0;
  localparam int unsigned RX_JITTER = 1;
  localparam int unsigned RX_SPARSE = 2;

  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 16;   // margin for the calc pipe to clear
  localparam int unsigned RANDOM_CELLS  = 800;
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;

  // --------------------------------------------------------------------------
  // Scoreboard: one Jacobi step, mirrored beat by beat
  // --------------------------------------------------------------------------
  class heat_step_board;
    logic [GW_W-1:0]   grid_width;
    logic [ROW_W-1:0]  grid_height;
    logic [COL_W-1:0]  hot_col;
    logic [ROW_W-1:0]  hot_row;

    // above_line: row y-1 left of the cursor, row y-2 right of it
    // cur_line:   row y left of the cursor, row y-1 right of it
    logic [TEMP_W-1:0] above_line [MAX_WIDTH_DEF];
    logic [TEMP_W-1:0] cur_line   [MAX_WIDTH_DEF];
    int unsigned       col_count;
    int unsigned       row_count;
    int unsigned       drain_col;
    bit                draining;

    result_t           due_cells [$];
    int unsigned       mismatch_count;

    function void clear();
      grid_width  = GRID_WIDTH_RST;
      grid_height = GRID_HEIGHT_RST;
      hot_col     = HOT_COL_RST;
      hot_row     = HOT_ROW_RST;
      foreach (above_line[i]) begin
        above_line[i] = '0;
        cur_line[i]   = '0;
      end
      col_count = 0;
      row_count = 0;
      drain_col = 0;
      draining  = 1'b0;
      due_cells.delete();
      mismatch_count = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_GRID_WIDTH:  grid_width  = value[GW_W-1:0];
        REG_GRID_HEIGHT: grid_height = value[ROW_W-1:0];
        REG_HOT_COL:     hot_col     = value[COL_W-1:0];
        REG_HOT_ROW:     hot_row     = value[ROW_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned cols_in_use();
      if (grid_width == 0) return 1;
      if (grid_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return 32'(grid_width);
    endfunction

    function int unsigned rows_in_use();
      return (grid_height == 0) ? 1 : 32'(grid_height);
    endfunction

    // floor of the five-point mean, source cell kept; missing neighbors fall back to the center
    function logic [TEMP_W-1:0] relax_cell(int unsigned x, int unsigned y,
                                           int unsigned w, bit has_up,
                                           bit has_down, logic [TEMP_W-1:0] below);
      logic [TEMP_W-1:0] ctr, lft, rgt, up_v, dn_v;
      logic [SUM_W-1:0]  sum;
      ctr  = cur_line[x];
      lft  = (x > 0) ? above_line[x-1] : ctr;
      rgt  = (x + 1 < w) ? cur_line[x+1] : ctr;
      up_v = has_up ? above_line[x] : ctr;
      dn_v = has_down ? below : ctr;
      if (x == hot_col && y == hot_row) return ctr;
      sum = SUM_W'(ctr) + SUM_W'(lft) + SUM_W'(rgt) + SUM_W'(up_v) + SUM_W'(dn_v);
      return TEMP_W'(sum / 5);
    endfunction

    // accepted input beat: advance state, queue the result it causes
    function void take_beat(bit is_drain, logic [TEMP_W-1:0] t);
      int unsigned w, h, x, y;
      result_t     res;
      w = cols_in_use();
      h = rows_in_use();
      if (is_drain) begin
        if (!draining) return;
        x = (drain_col >= w) ? w - 1 : drain_col;
        res.temp = relax_cell(x, row_count, w, row_count > 0, 1'b0, '0);
        res.col  = COL_W'(x);
        res.row  = ROW_W'(row_count);
        res.last = (x + 1 >= w);
        due_cells.push_back(res);
        above_line[x] = cur_line[x];
        if (x + 1 >= w) begin
          draining  = 1'b0;
          drain_col = 0;
          row_count = 0;
        end else begin
          drain_col = x + 1;
        end
        return;
      end
      // a cell while draining starts a fresh frame
      if (draining) begin
        draining  = 1'b0;
        drain_col = 0;
        row_count = 0;
        col_count = 0;
      end
      if (col_count >= w) col_count = w - 1;
      if (row_count > 0) begin
        y = row_count - 1;
        res.temp = relax_cell(col_count, y, w, y > 0, 1'b1, t);
        res.col  = COL_W'(col_count);
        res.row  = ROW_W'(y);
        res.last = 1'b0;
        due_cells.push_back(res);
      end
      above_line[col_count] = cur_line[col_count];
      cur_line[col_count]   = t;
      if (col_count + 1 >= w) begin
        col_count = 0;
        if (row_count + 1 >= h) begin
          draining  = 1'b1;
          drain_col = 0;
        end else begin
          row_count = (row_count + 1) & 16'hFFFF;
        end
      end else begin
        col_count++;
      end
    endfunction

    function void flag(string name, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatch_count++;
    endfunction

    function void check_cell(result_t got);
      result_t want;
      if (due_cells.size() == 0) begin
        $display("%0t: unexpected result, expected none, got temp 0x%0h col %0d row %0d",
                 $time, got.temp, got.col, got.row);
        mismatch_count++;
        return;
      end
      want = due_cells.pop_front();
      if (got.temp !== want.temp) flag("new_temperature", 32'(want.temp), 32'(got.temp));
      if (got.col  !== want.col)  flag("col", 32'(want.col), 32'(got.col));
      if (got.row  !== want.row)  flag("row", 32'(want.row), 32'(got.row));
      if (got.last !== want.last) flag("frame_last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 cmd;
  logic [TEMP_W-1:0]    temperature;
  logic                 out_valid;
  logic                 out_ready;
  logic [TEMP_W-1:0]    new_temperature;
  logic [COL_W-1:0]     col;
  logic [ROW_W-1:0]     row;
  logic                 frame_last;

  heat_stencil_5pt_stream dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .temperature     (temperature),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .new_temperature (new_temperature),
    .col             (col),
    .row             (row),
    .frame_last      (frame_last)
  );

  always #5 clk = ~clk;

  heat_step_board board;
  int unsigned    cycle_count = 0;
  int unsigned    burst_left  = 0;
  int unsigned    cell_count  = 0;
  bit             hold_req    = 1'b0;
  bit             hold_arm    = 1'b0;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // output monitor: a beat moves when valid and ready are both high at the edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_cell('{new_temperature, col, row, frame_last});
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall patterns, each held for a random run, plus a
  // long hold-off on request so the output queue fills and in_ready drops
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned mode, mode_left, stall_run, tick;
    out_ready = 1'b0;
    mode      = RX_OPEN;
    mode_left = 0;
    stall_run = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(RX_OPEN, RX_SPARSE);
          mode_left = $urandom_range(20, 400);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_OPEN: out_ready <= 1'b1;
          RX_JITTER: begin
            // stall_run caps how long a stall lasts
            if (stall_run < 3 && $urandom_range(0, 1) == 1) begin
              out_ready <= 1'b0;
              stall_run++;
            end else begin
              out_ready <= 1'b1;
              stall_run = 0;
            end
          end
          default: out_ready <= (tick % 4 == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  function automatic logic [TEMP_W-1:0] pick_temp();
    case ($urandom_range(0, 7))
      0:       return T_COLD;
      1:       return T_HOT;
      2:       return TEMP_W'($urandom_range(0, 15));
      3:       return T_HOT - TEMP_W'($urandom_range(0, 15));
      default: return TEMP_W'($urandom);
    endcase
  endfunction

  // one input beat; bursts of random length separated by random gaps
  task automatic send_beat(bit c, logic [TEMP_W-1:0] t);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid    <= 1'b1;
    cmd         <= c;
    temperature <= t;
    do @(posedge clk); while (!in_ready);
    board.take_beat(c, t);
  endtask

  // drop valid, wait for every expected result, then let no-result beats clear
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.due_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, value);
  endtask

  // one frame of cells in raster order, with an occasional extra drain beat
  task automatic stream_frame(int unsigned w, int unsigned h);
    for (int unsigned y = 0; y < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        if ($urandom_range(0, 19) == 0) send_beat(CMD_DRAIN, pick_temp());
        send_beat(CMD_CELL, pick_temp());
        cell_count++;
      end
    end
  endtask

  // flush the last row; a partial flush is abandoned by the next frame
  task automatic end_frame(int unsigned w, bit full);
    int unsigned n;
    n = w;
    if (!full && $urandom_range(0, 3) == 0) n = $urandom_range(0, w - 1);
    repeat (n) send_beat(CMD_DRAIN, pick_temp());
    if (n == w && $urandom_range(0, 3) == 0) send_beat(CMD_DRAIN, pick_temp());
  endtask

  task automatic run_phase(int unsigned gw, int unsigned gh, int unsigned sx,
                           int unsigned sy, int unsigned frames);
    int unsigned w, h;
    settle();
    write_reg(REG_GRID_WIDTH,  CFG_W'(gw));
    write_reg(REG_GRID_HEIGHT, CFG_W'(gh));
    write_reg(REG_HOT_COL,     CFG_W'(sx));
    write_reg(REG_HOT_ROW,     CFG_W'(sy));
    // hold-off starts only once the sender is about to stream
    if (hold_arm) begin
      hold_arm = 1'b0;
      hold_req = 1'b1;
    end
    w = board.cols_in_use();
    h = board.rows_in_use();
    for (int unsigned f = 0; f < frames; f++) begin
      stream_frame(w, h);
      end_frame(w, f + 1 == frames);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned gw, gh, sx, sy;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_GRID_WIDTH;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    cmd         = CMD_CELL;
    temperature = '0;
    board = new;
    board.clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 3x3 frame of extremes, source in the middle; row 0 gives nothing,
    // the leading drain is stray
    write_reg(REG_GRID_WIDTH,  CFG_W'(3));
    write_reg(REG_GRID_HEIGHT, CFG_W'(3));
    write_reg(REG_HOT_COL,     CFG_W'(1));
    write_reg(REG_HOT_ROW,     CFG_W'(1));
    send_beat(CMD_DRAIN, T_HOT);
    send_beat(CMD_CELL, T_HOT);
    send_beat(CMD_CELL, T_COLD);
    send_beat(CMD_CELL, T_HOT);
    send_beat(CMD_CELL, T_COLD);
    send_beat(CMD_CELL, T_HOT);
    send_beat(CMD_CELL, T_COLD);
    send_beat(CMD_CELL, T_HOT);
    send_beat(CMD_CELL, T_HOT);
    send_beat(CMD_CELL, T_COLD);
    repeat (3) send_beat(CMD_DRAIN, T_COLD);

    // geometry shrunk mid-frame: 4x4 frame cut to 2x3 two cells into row 2,
    // so the column clamps and the frame ends at once
    settle();
    write_reg(REG_GRID_WIDTH,  CFG_W'(4));
    write_reg(REG_GRID_HEIGHT, CFG_W'(4));
    write_reg(REG_HOT_COL,     CFG_W'(3));
    write_reg(REG_HOT_ROW,     CFG_W'(0));
    for (int i = 0; i < 10; i++) send_beat(CMD_CELL, (i % 3 == 0) ? T_COLD : T_HOT);
    settle();
    write_reg(REG_GRID_WIDTH,  CFG_W'(2));
    write_reg(REG_GRID_HEIGHT, CFG_W'(3));
    send_beat(CMD_CELL, T_HOT);
    repeat (2) send_beat(CMD_DRAIN, T_COLD);

    // random geometries, mostly small; first phase runs under a long hold-off
    hold_arm = 1'b1;
    while (cell_count < RANDOM_CELLS) begin
      gw = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
      gh = $urandom_range(1, 6);
      if ($urandom_range(0, 2) != 0) begin
        sx = $urandom_range(0, gw - 1);
        sy = $urandom_range(0, gh - 1);
      end else begin
        sx = $urandom_range(0, 1023);
        sy = $urandom_range(0, 65535);
      end
      run_phase(gw, gh, sx, sy, $urandom_range(1, 4));
    end

    // register extremes: zero width and height act as one
    run_phase(0, 3, 0, 1, 3);
    run_phase(4, 0, 3, 0, 3);
    // wide frame under a long hold-off, source in the last column of the last row
    hold_arm = 1'b1;
    run_phase(64, 4, 63, 3, 1);

    settle();
    if (board.mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/hs5_pkg.sv
rtl/hs5_ram.sv
rtl/hs5_calc.sv
rtl/hs5_outq.sv
rtl/heat_stencil_5pt_stream.sv
rtl/hs5_checker.sv
tb/heat_stencil_5pt_stream_tb.sv
